// ----- rtl/scissor_clip_fill_blit_setup_core_defines.svh -----
// Assertion helpers for the fill/blit set-up core.
`ifndef SCISSOR_CLIP_FILL_BLIT_SETUP_CORE_DEFINES_SVH
`define SCISSOR_CLIP_FILL_BLIT_SETUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication across the full command-to-result latency.
`define SCFB_ASSERT_LAT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##5 (cons)) \
        else $error(msg);

`endif

// ----- rtl/scfb_pkg.sv -----
package scfb_pkg;

    // Dimension and pitch limits; larger register or field values saturate.
    localparam int MAX_DIM    = 4096;
    localparam int MAX_STRIDE = 8192;

    // Working width of signed coordinates inside the clip pipeline.
    localparam int CW = 18;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    // Command kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CLEAR = 2'd0;
    localparam t_kind KIND_SPAN  = 2'd1;
    localparam t_kind KIND_COPY  = 2'd2;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FILL_COLOR = 3'd0;
    localparam t_cfg_idx CFG_FB_WIDTH   = 3'd1;
    localparam t_cfg_idx CFG_FB_HEIGHT  = 3'd2;
    localparam t_cfg_idx CFG_FB_STRIDE  = 3'd3;
    localparam t_cfg_idx CFG_SCISSOR_X  = 3'd4;
    localparam t_cfg_idx CFG_SCISSOR_Y  = 3'd5;
    localparam t_cfg_idx CFG_SCISSOR_W  = 3'd6;
    localparam t_cfg_idx CFG_SCISSOR_H  = 3'd7;

    typedef struct packed {
        logic [31:0]        fill_color;
        logic [12:0]        fb_width;
        logic [12:0]        fb_height;
        logic [13:0]        fb_stride;
        logic signed [15:0] scissor_x;
        logic signed [15:0] scissor_y;
        logic [14:0]        scissor_w;
        logic [14:0]        scissor_h;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        fill_color: 32'hFFFF_FFFF,
        fb_width:   13'd640,
        fb_height:  13'd480,
        fb_stride:  14'd640,
        scissor_x:  16'sd0,
        scissor_y:  16'sd0,
        scissor_w:  15'd32767,
        scissor_h:  15'd32767
    };

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [14:0]        req_width;
        logic [14:0]        req_height;
        logic [14:0]        src_x;
        logic [14:0]        src_y;
        logic [12:0]        src_width;
        logic [12:0]        src_height;
        logic [13:0]        src_pitch;
    } t_cmd;

    typedef struct packed {
        logic        nonempty;
        logic        is_copy;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_width;
        logic [12:0] out_height;
        logic [24:0] dest_offset;
        logic [24:0] src_offset;
        logic [31:0] color_out;
    } t_res;

    // Clipped command handed from the clip pipeline to the offset stage.
    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        is_copy;
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [13:0] dstride;
        logic [13:0] sstride;
        logic [31:0] color;
    } t_clip;

endpackage

// ----- rtl/scfb_clip.sv -----
module scfb_clip (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_v,
    input  scfb_pkg::t_cmd   i_cmd,
    input  scfb_pkg::t_cfg   i_cfg,
    output scfb_pkg::t_clip  o_clip
);
    import scfb_pkg::*;

    function automatic t_coord smax(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord smin(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [12:0] cap_dim(input logic [12:0] v);
        return (v > 13'(MAX_DIM)) ? 13'(MAX_DIM) : v;
    endfunction

    function automatic logic [13:0] cap_stride(input logic [13:0] v);
        return (v > 14'(MAX_STRIDE)) ? 14'(MAX_STRIDE) : v;
    endfunction

    // ---------------- stage 1: effective scissor and request edges
    logic        r1_v, n1_v;
    logic        r1_is_copy, n1_is_copy;
    t_coord      r1_qx0, r1_qx1, r1_qy0, r1_qy1;
    t_coord      n1_qx0, n1_qx1, n1_qy0, n1_qy1;
    logic [12:0] r1_scx0, r1_scx1, r1_scy0, r1_scy1;
    logic [12:0] n1_scx0, n1_scx1, n1_scy0, n1_scy1;
    t_coord      r1_dsx, r1_dsy, n1_dsx, n1_dsy;
    logic [12:0] r1_sw, r1_sh, n1_sw, n1_sh;
    logic [13:0] r1_sstride, r1_dstride, n1_sstride, n1_dstride;
    logic [31:0] r1_color, n1_color;

    t_coord      s1_ex0, s1_ex1, s1_ey0, s1_ey1;
    logic        s1_sc_ok;

    always_comb begin
        // scissor against framebuffer bounds; empty collapses to origin
        s1_ex0   = smax(t_coord'(i_cfg.scissor_x), '0);
        s1_ey0   = smax(t_coord'(i_cfg.scissor_y), '0);
        s1_ex1   = smin(t_coord'(i_cfg.scissor_x) + t_coord'(i_cfg.scissor_w),
                        t_coord'(cap_dim(i_cfg.fb_width)));
        s1_ey1   = smin(t_coord'(i_cfg.scissor_y) + t_coord'(i_cfg.scissor_h),
                        t_coord'(cap_dim(i_cfg.fb_height)));
        s1_sc_ok = (s1_ex1 > s1_ex0) && (s1_ey1 > s1_ey0);

        n1_v    = i_cmd_v;
        n1_scx0 = s1_sc_ok ? s1_ex0[12:0] : '0;
        n1_scx1 = s1_sc_ok ? s1_ex1[12:0] : '0;
        n1_scy0 = s1_sc_ok ? s1_ey0[12:0] : '0;
        n1_scy1 = s1_sc_ok ? s1_ey1[12:0] : '0;

        // request box per kind; a clear takes an unbounded box
        n1_is_copy = 1'b0;
        n1_color   = '0;
        case (i_cmd.kind)
            KIND_CLEAR: begin
                n1_qx0   = COORD_MIN;
                n1_qx1   = COORD_MAX;
                n1_qy0   = COORD_MIN;
                n1_qy1   = COORD_MAX;
                n1_color = i_cfg.fill_color;
            end
            KIND_SPAN: begin
                n1_qx0   = t_coord'(i_cmd.dest_x);
                n1_qx1   = t_coord'(i_cmd.dest_x) + t_coord'(i_cmd.req_width);
                n1_qy0   = t_coord'(i_cmd.dest_y);
                n1_qy1   = t_coord'(i_cmd.dest_y) + t_coord'(1);
                n1_color = i_cfg.fill_color;
            end
            KIND_COPY: begin
                n1_qx0     = t_coord'(i_cmd.dest_x);
                n1_qx1     = t_coord'(i_cmd.dest_x) + t_coord'(i_cmd.req_width);
                n1_qy0     = t_coord'(i_cmd.dest_y);
                n1_qy1     = t_coord'(i_cmd.dest_y) + t_coord'(i_cmd.req_height);
                n1_is_copy = 1'b1;
            end
            default: begin
                n1_qx0 = '0;
                n1_qx1 = '0;
                n1_qy0 = '0;
                n1_qy1 = '0;
            end
        endcase

        // source origin minus destination origin, before clip shift
        n1_dsx     = t_coord'(i_cmd.src_x) - t_coord'(i_cmd.dest_x);
        n1_dsy     = t_coord'(i_cmd.src_y) - t_coord'(i_cmd.dest_y);
        n1_sw      = cap_dim(i_cmd.src_width);
        n1_sh      = cap_dim(i_cmd.src_height);
        n1_sstride = cap_stride(i_cmd.src_pitch);
        n1_dstride = cap_stride(i_cfg.fb_stride);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= n1_v;
        end
        r1_is_copy <= n1_is_copy;
        r1_qx0     <= n1_qx0;
        r1_qx1     <= n1_qx1;
        r1_qy0     <= n1_qy0;
        r1_qy1     <= n1_qy1;
        r1_scx0    <= n1_scx0;
        r1_scx1    <= n1_scx1;
        r1_scy0    <= n1_scy0;
        r1_scy1    <= n1_scy1;
        r1_dsx     <= n1_dsx;
        r1_dsy     <= n1_dsy;
        r1_sw      <= n1_sw;
        r1_sh      <= n1_sh;
        r1_sstride <= n1_sstride;
        r1_dstride <= n1_dstride;
        r1_color   <= n1_color;
    end

    // ---------------- stage 2: destination clip and source shift
    logic        r2_v, r2_ok, r2_is_copy;
    logic [11:0] r2_x, r2_y;
    logic [12:0] r2_w, r2_h;
    logic [16:0] r2_srqx, r2_srqy;
    logic [12:0] r2_sw, r2_sh;
    logic [13:0] r2_sstride, r2_dstride;
    logic [31:0] r2_color;

    t_coord      s2_x0, s2_x1, s2_y0, s2_y1, s2_w, s2_h, s2_srqx, s2_srqy;
    logic        n2_ok;

    always_comb begin
        s2_x0   = smax(r1_qx0, t_coord'(r1_scx0));
        s2_x1   = smin(r1_qx1, t_coord'(r1_scx1));
        s2_y0   = smax(r1_qy0, t_coord'(r1_scy0));
        s2_y1   = smin(r1_qy1, t_coord'(r1_scy1));
        n2_ok   = (s2_x1 > s2_x0) && (s2_y1 > s2_y0);
        s2_w    = s2_x1 - s2_x0;
        s2_h    = s2_y1 - s2_y0;
        s2_srqx = r1_dsx + s2_x0;
        s2_srqy = r1_dsy + s2_y0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ok      <= n2_ok;
        r2_is_copy <= r1_is_copy;
        r2_x       <= s2_x0[11:0];
        r2_y       <= s2_y0[11:0];
        r2_w       <= s2_w[12:0];
        r2_h       <= s2_h[12:0];
        r2_srqx    <= s2_srqx[16:0];
        r2_srqy    <= s2_srqy[16:0];
        r2_sw      <= r1_sw;
        r2_sh      <= r1_sh;
        r2_sstride <= r1_sstride;
        r2_dstride <= r1_dstride;
        r2_color   <= r1_color;
    end

    // ---------------- stage 3: source clip, shrink copy extent
    t_clip       r3_clip, n3_clip;
    logic        s3_in_x, s3_in_y;
    logic [12:0] s3_rem_x, s3_rem_y, s3_sw, s3_sh;

    always_comb begin
        s3_in_x  = r2_srqx < 17'(r2_sw);
        s3_in_y  = r2_srqy < 17'(r2_sh);
        s3_rem_x = r2_sw - r2_srqx[12:0];
        s3_rem_y = r2_sh - r2_srqy[12:0];
        s3_sw    = (r2_w < s3_rem_x) ? r2_w : s3_rem_x;
        s3_sh    = (r2_h < s3_rem_y) ? r2_h : s3_rem_y;

        n3_clip.vld     = r2_v;
        n3_clip.is_copy = r2_is_copy;
        n3_clip.x       = r2_x;
        n3_clip.y       = r2_y;
        n3_clip.dstride = r2_dstride;
        n3_clip.sstride = r2_sstride;
        n3_clip.color   = r2_color;
        if (r2_is_copy) begin
            n3_clip.ok    = r2_ok && s3_in_x && s3_in_y;
            n3_clip.w     = s3_sw;
            n3_clip.h     = s3_sh;
            n3_clip.src_x = r2_srqx[11:0];
            n3_clip.src_y = r2_srqy[11:0];
        end else begin
            n3_clip.ok    = r2_ok;
            n3_clip.w     = r2_w;
            n3_clip.h     = r2_h;
            n3_clip.src_x = '0;
            n3_clip.src_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_clip <= '0;
        end else begin
            r3_clip <= n3_clip;
        end
    end

    assign o_clip = r3_clip;

endmodule

// ----- rtl/scissor_clip_fill_blit_setup_core.sv -----
// Channel   Handshake                  Payload            Direction
// command   start / busy               i_cmd  (t_cmd)     in
// result    o_res_stb (one cycle)      o_res  (t_res)     out
// config    i_cfg_we                   i_cfg_idx, i_cfg_data  in
//
// One command per clock; busy stays low. Each result passes the input register, three
// clip stages, then the offset multiply into the result register. Synchronous
// active-low reset clears the valid bits and loads the register defaults.
// Results are shown for exactly one cycle; the receiver cannot stall.
`include "scissor_clip_fill_blit_setup_core_defines.svh"

module scissor_clip_fill_blit_setup_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  scfb_pkg::t_cmd      i_cmd,
    input  logic                i_cfg_we,
    input  scfb_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_res_stb,
    output scfb_pkg::t_res      o_res
);
    import scfb_pkg::*;

    t_cfg  r_cfg;
    logic  r_cmd_v;
    t_cmd  r_cmd;
    t_clip w_clip;
    logic  r_res_stb;
    t_res  r_res, n_res;
    logic [25:0] w_dprod, w_sprod;
    logic  w_area_ok, w_empty_ok, w_payload_ok;

    // never stalls the command side
    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILL_COLOR: r_cfg.fill_color <= i_cfg_data;
                CFG_FB_WIDTH:   r_cfg.fb_width   <= i_cfg_data[12:0];
                CFG_FB_HEIGHT:  r_cfg.fb_height  <= i_cfg_data[12:0];
                CFG_FB_STRIDE:  r_cfg.fb_stride  <= i_cfg_data[13:0];
                CFG_SCISSOR_X:  r_cfg.scissor_x  <= signed'(i_cfg_data[15:0]);
                CFG_SCISSOR_Y:  r_cfg.scissor_y  <= signed'(i_cfg_data[15:0]);
                CFG_SCISSOR_W:  r_cfg.scissor_w  <= i_cfg_data[14:0];
                CFG_SCISSOR_H:  r_cfg.scissor_h  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= 1'b0;
        end else begin
            r_cmd_v <= start && !busy;
        end
        r_cmd <= i_cmd;
    end

    scfb_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd_v (r_cmd_v),
        .i_cmd   (r_cmd),
        .i_cfg   (r_cfg),
        .o_clip  (w_clip)
    );

    // row offsets, then zero the geometry and offsets for an empty result
    assign w_dprod = w_clip.y * w_clip.dstride;
    assign w_sprod = w_clip.src_y * w_clip.sstride;

    always_comb begin
        n_res.nonempty    = w_clip.ok;
        n_res.is_copy     = w_clip.is_copy;
        n_res.color_out   = w_clip.color;
        n_res.out_x       = w_clip.ok ? w_clip.x : '0;
        n_res.out_y       = w_clip.ok ? w_clip.y : '0;
        n_res.out_width   = w_clip.ok ? w_clip.w : '0;
        n_res.out_height  = w_clip.ok ? w_clip.h : '0;
        n_res.dest_offset = w_clip.ok ? (w_dprod[24:0] + 25'(w_clip.x)) : '0;
        n_res.src_offset  = w_clip.ok ? (w_sprod[24:0] + 25'(w_clip.src_x)) : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_stb <= 1'b0;
        end else begin
            r_res_stb <= w_clip.vld;
        end
        r_res <= n_res;
    end

    assign o_res_stb = r_res_stb;
    assign o_res     = r_res;

    // result checks used by the assertions
    assign w_area_ok    = (o_res.out_width != 13'd0) && (o_res.out_height != 13'd0);
    assign w_empty_ok   = (o_res.out_width == 13'd0) && (o_res.dest_offset == 25'd0)
                          && (o_res.src_offset == 25'd0);
    assign w_payload_ok = o_res.is_copy ? (o_res.color_out == 32'd0)
                                        : (o_res.src_offset == 25'd0);

    // every accepted command yields a result strobe after the pipeline
    `SCFB_ASSERT_LAT(a_res_latency, i_clk, i_rst_n, start && !busy, o_res_stb, "result missing")
    // a non-empty result covers at least one pixel
    `SCFB_ASSERT_IMP(a_nonempty_area, i_clk, i_rst_n, o_res_stb && o_res.nonempty, w_area_ok, "no area")
    // an empty result carries no geometry
    `SCFB_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_res_stb && !o_res.nonempty, w_empty_ok, "empty")
    // copies carry no color, fills no source offset
    `SCFB_ASSERT_IMP(a_copy_fill, i_clk, i_rst_n, o_res_stb, w_payload_ok, "payload mix-up")

endmodule

// ----- bench/tb_scissor_clip_fill_blit_setup_core.sv -----
`timescale 1ns / 100ps

module tb_scissor_clip_fill_blit_setup_core;
    import scfb_pkg::*;

    localparam int    RESULT_LATENCY = 5;
    localparam t_kind KIND_UNDEF     = 2'd3;

    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } t_rect;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_res_stb;
    t_res        o_res;

    // Register copy seen by the predictor, pending clipped setups, error count
    t_cfg cfg_shadow = CFG_RESET;
    t_res pending_setups[$];
    int   mismatch_count = 0;
    bit   idle_gaps = 1'b1;
    t_res want;

    scissor_clip_fill_blit_setup_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res_stb  (o_res_stb),
        .o_res      (o_res)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop if results never arrive
    initial begin
        #400_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
    endtask

    function automatic longint cap_to(input longint v, input longint lim);
        return (v > lim) ? lim : v;
    endfunction

    // Plain rectangle intersection; empty gives the zero rectangle
    function automatic bit rect_overlap(input t_rect a, input t_rect b, output t_rect r);
        longint x0, x1, y0, y1;
        x0 = (a.x > b.x) ? a.x : b.x;
        y0 = (a.y > b.y) ? a.y : b.y;
        x1 = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
        y1 = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
        if (x1 <= x0 || y1 <= y0) begin
            r = '{0, 0, 0, 0};
            return 1'b0;
        end
        r = '{x0, y0, x1 - x0, y1 - y0};
        return 1'b1;
    endfunction

    // Work out the clipped setup word for one command under the current registers
    function automatic t_res predict_setup(input t_cmd c);
        t_rect  scis_req, fb, scis, req, d, sreq, sbounds, sr;
        longint dstride, sstride, soff, doff;
        bit     ok, copy;
        t_res   r;
        r    = '0;
        ok   = 1'b0;
        copy = 1'b0;
        soff = 0;
        d    = '{0, 0, 0, 0};
        scis_req = '{longint'($signed(cfg_shadow.scissor_x)),
                     longint'($signed(cfg_shadow.scissor_y)),
                     longint'(cfg_shadow.scissor_w), longint'(cfg_shadow.scissor_h)};
        fb = '{0, 0, cap_to(longint'(cfg_shadow.fb_width), MAX_DIM),
               cap_to(longint'(cfg_shadow.fb_height), MAX_DIM)};
        void'(rect_overlap(scis_req, fb, scis));
        dstride = cap_to(longint'(cfg_shadow.fb_stride), MAX_STRIDE);
        sstride = cap_to(longint'(c.src_pitch), MAX_STRIDE);
        req = '{longint'($signed(c.dest_x)), longint'($signed(c.dest_y)),
                longint'(c.req_width), longint'(c.req_height)};
        case (c.kind)
            KIND_CLEAR: begin
                d  = scis;
                ok = scis.w > 0 && scis.h > 0;
                r.color_out = cfg_shadow.fill_color;
            end
            KIND_SPAN: begin
                req.h = 1;
                ok = rect_overlap(req, scis, d);
                r.color_out = cfg_shadow.fill_color;
            end
            KIND_COPY: begin
                copy = 1'b1;
                ok = rect_overlap(req, scis, d);
                if (ok) begin
                    // shift the source by what was clipped off left and top
                    sreq = '{longint'(c.src_x) + (d.x - req.x),
                             longint'(c.src_y) + (d.y - req.y), d.w, d.h};
                    sbounds = '{0, 0, cap_to(longint'(c.src_width), MAX_DIM),
                                cap_to(longint'(c.src_height), MAX_DIM)};
                    ok = rect_overlap(sreq, sbounds, sr);
                    if (ok) begin
                        d.w  = sr.w;
                        d.h  = sr.h;
                        soff = sr.y * sstride + sr.x;
                    end
                end
            end
            default: return '0;
        endcase
        r.is_copy = copy;
        if (ok) begin
            doff = d.y * dstride + d.x;
            r.nonempty    = 1'b1;
            r.out_x       = d.x[11:0];
            r.out_y       = d.y[11:0];
            r.out_width   = d.w[12:0];
            r.out_height  = d.h[12:0];
            r.dest_offset = doff[24:0];
            r.src_offset  = soff[24:0];
        end
        return r;
    endfunction

    // Compare each result word with the oldest pending setup
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_stb) begin
            if (pending_setups.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_setups.pop_front();
                compare_field("nonempty", o_res.nonempty, want.nonempty);
                compare_field("is_copy", o_res.is_copy, want.is_copy);
                compare_field("out_x", o_res.out_x, want.out_x);
                compare_field("out_y", o_res.out_y, want.out_y);
                compare_field("out_width", o_res.out_width, want.out_width);
                compare_field("out_height", o_res.out_height, want.out_height);
                compare_field("dest_offset", o_res.dest_offset, want.dest_offset);
                compare_field("src_offset", o_res.src_offset, want.src_offset);
                compare_field("color_out", o_res.color_out, want.color_out);
            end
        end
    end

    // Send one command word, with an optional idle gap ahead of it
    task automatic send_cmd(input t_cmd c);
        int gap, pick;
        gap = 0;
        if (idle_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                gap = $urandom_range(8, 40);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_setups.push_back(predict_setup(c));
    endtask

    // Hold off until every pending result has arrived, then let the pipe empty
    task automatic wait_for_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_setups.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_setups.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_setups.size()));
            pending_setups.delete();
        end
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    // Write one register; noisy fills the bits above the register with junk
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value,
                             input bit noisy);
        logic [31:0] mask, data;
        case (idx)
            CFG_FILL_COLOR: mask = 32'hFFFF_FFFF;
            CFG_FB_WIDTH, CFG_FB_HEIGHT: mask = 32'h1FFF;
            CFG_FB_STRIDE: mask = 32'h3FFF;
            CFG_SCISSOR_X, CFG_SCISSOR_Y: mask = 32'hFFFF;
            default: mask = 32'h7FFF;
        endcase
        data = value & mask;
        if (noisy)
            data = data | ($urandom() & ~mask);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FILL_COLOR: cfg_shadow.fill_color = data;
            CFG_FB_WIDTH:   cfg_shadow.fb_width   = data[12:0];
            CFG_FB_HEIGHT:  cfg_shadow.fb_height  = data[12:0];
            CFG_FB_STRIDE:  cfg_shadow.fb_stride  = data[13:0];
            CFG_SCISSOR_X:  cfg_shadow.scissor_x  = data[15:0];
            CFG_SCISSOR_Y:  cfg_shadow.scissor_y  = data[15:0];
            CFG_SCISSOR_W:  cfg_shadow.scissor_w  = data[14:0];
            default:        cfg_shadow.scissor_h  = data[14:0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] color, input int fbw, input int fbh,
                              input int fbs, input int scx, input int scy,
                              input int scw, input int sch, input bit noisy);
        write_reg(CFG_FILL_COLOR, color, noisy);
        write_reg(CFG_FB_WIDTH, 32'(fbw), noisy);
        write_reg(CFG_FB_HEIGHT, 32'(fbh), noisy);
        write_reg(CFG_FB_STRIDE, 32'(fbs), noisy);
        write_reg(CFG_SCISSOR_X, 32'(scx), noisy);
        write_reg(CFG_SCISSOR_Y, 32'(scy), noisy);
        write_reg(CFG_SCISSOR_W, 32'(scw), noisy);
        write_reg(CFG_SCISSOR_H, 32'(sch), noisy);
    endtask

    function automatic t_cmd make_cmd(input t_kind k, input int dx, input int dy,
                                      input int rw, input int rh, input int sx,
                                      input int sy, input int sw, input int sh,
                                      input int ss);
        t_cmd c;
        c.kind       = k;
        c.dest_x     = 16'(dx);
        c.dest_y     = 16'(dy);
        c.req_width  = 15'(rw);
        c.req_height = 15'(rh);
        c.src_x      = 15'(sx);
        c.src_y      = 15'(sy);
        c.src_width  = 13'(sw);
        c.src_height = 13'(sh);
        c.src_pitch  = 14'(ss);
        return c;
    endfunction

    // Mostly commands aimed around the framebuffer, some raw noise
    function automatic t_cmd random_cmd();
        logic [159:0] noise;
        int fw, fh, sw, sh, pick;
        t_kind k;
        if ($urandom_range(0, 9) == 0) begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            return noise[$bits(t_cmd)-1:0];
        end
        fw = int'(cap_to(longint'(cfg_shadow.fb_width), MAX_DIM));
        fh = int'(cap_to(longint'(cfg_shadow.fb_height), MAX_DIM));
        pick = $urandom_range(0, 19);
        if (pick < 2)       k = KIND_CLEAR;
        else if (pick < 9)  k = KIND_SPAN;
        else if (pick < 19) k = KIND_COPY;
        else                k = KIND_UNDEF;
        pick = $urandom_range(0, 9);
        sw = (pick == 0) ? MAX_DIM : (pick == 1) ? $urandom_range(4097, 8191)
                                   : $urandom_range(0, 600);
        pick = $urandom_range(0, 9);
        sh = (pick == 0) ? MAX_DIM : (pick == 1) ? $urandom_range(4097, 8191)
                                   : $urandom_range(0, 600);
        return make_cmd(k,
            ($urandom_range(0, 15) == 0) ? int'($urandom()) :
                int'($urandom_range(0, fw + 200)) - 100,
            ($urandom_range(0, 15) == 0) ? int'($urandom()) :
                int'($urandom_range(0, fh + 200)) - 100,
            ($urandom_range(0, 9) == 0) ? 32767 : int'($urandom_range(0, fw + 50)),
            ($urandom_range(0, 9) == 0) ? 32767 : int'($urandom_range(0, fh + 50)),
            ($urandom_range(0, 15) == 0) ? int'($urandom()) :
                int'($urandom_range(0, (sw > 4096 ? 4096 : sw) + 20)),
            ($urandom_range(0, 15) == 0) ? int'($urandom()) :
                int'($urandom_range(0, (sh > 4096 ? 4096 : sh) + 20)),
            sw, sh,
            ($urandom_range(0, 15) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? int'($urandom_range(8192, 16383)) :
                int'($urandom_range(1, 1024)));
    endfunction

    // Reset register values: full-frame clear, spans off the left, right and top edges, zero-width span, undefined kind
    task automatic test_reset_defaults();
        send_cmd(make_cmd(KIND_CLEAR, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        send_cmd(make_cmd(KIND_SPAN, -32768, 0, 32767, 77, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_SPAN, 32767, 479, 32767, 0, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(KIND_SPAN, 10, -1, 100, 1, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(KIND_SPAN, 10, 10, 0, 1, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(KIND_UNDEF, -1, -1, 32767, 32767, 32767, 32767, 8191, 8191,
                          16383));
    endtask

    // Copies: source shift, oversized source, zero source size, zero stride
    task automatic test_copy_clip();
        send_cmd(make_cmd(KIND_COPY, -10, -20, 100, 100, 5, 5, 50, 4096, 8192));
        send_cmd(make_cmd(KIND_COPY, 600, 400, 200, 200, 4000, 4000, 8191, 8191, 16383));
        send_cmd(make_cmd(KIND_COPY, 0, 0, 64, 64, 0, 0, 0, 100, 100));
        send_cmd(make_cmd(KIND_COPY, 3, 7, 20, 20, 9, 11, 100, 100, 0));
        send_cmd(make_cmd(KIND_COPY, 32767, 32767, 32767, 32767, 32767, 32767, 4096,
                          4096, 8192));
        send_cmd(make_cmd(KIND_COPY, 0, 0, 32767, 32767, 0, 0, 4096, 4096, 4096));
    endtask

    // Register extremes: oversized framebuffer, empty scissor, zero stride, 1x1
    task automatic test_register_extremes();
        wait_for_results();
        set_config(32'h0, 8191, 8191, 16383, -32768, -32768, 32767, 32767, 1'b0);
        send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_SPAN, 4000, 4095, 32767, 0, 0, 0, 0, 0, 1));
        send_cmd(make_cmd(KIND_COPY, 4090, 4090, 100, 100, 4000, 4000, 4096, 4096,
                          8192));
        wait_for_results();
        set_config(32'hA5A5_5A5A, 640, 480, 0, 10, 10, 0, 100, 1'b0);
        send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(KIND_SPAN, 0, 20, 640, 0, 0, 0, 0, 0, 1));
        wait_for_results();
        set_config(32'h1234_5678, 1, 1, 1, 0, 0, 32767, 32767, 1'b0);
        send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_for_results();
        set_config(32'hFFFF_FFFF, 0, 480, 8192, 32767, 32767, 32767, 32767, 1'b0);
        send_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Random register settings per phase; some phases back to back, some gapped
    task automatic test_random_phases();
        int pick, fbw, fbh, fbs, scx, scy, scw, sch;
        for (int phase = 0; phase < 12; phase++) begin
            wait_for_results();
            pick = $urandom_range(0, 9);
            fbw = (pick == 0) ? 1 : (pick == 1) ? 4096 : (pick == 2) ?
                  int'($urandom_range(4097, 8191)) : int'($urandom_range(1, 700));
            pick = $urandom_range(0, 9);
            fbh = (pick == 0) ? 1 : (pick == 1) ? 4096 : (pick == 2) ?
                  int'($urandom_range(4097, 8191)) : int'($urandom_range(1, 700));
            pick = $urandom_range(0, 9);
            fbs = (pick == 0) ? 0 : (pick == 1) ? 8192 : (pick == 2) ?
                  int'($urandom_range(8193, 16383)) : int'($urandom_range(1, 2048));
            scx = ($urandom_range(0, 7) == 0) ? int'($urandom()) :
                  int'($urandom_range(0, 300)) - 100;
            scy = ($urandom_range(0, 7) == 0) ? int'($urandom()) :
                  int'($urandom_range(0, 300)) - 100;
            scw = ($urandom_range(0, 5) == 0) ? 32767 : int'($urandom_range(0, 900));
            sch = ($urandom_range(0, 5) == 0) ? 32767 : int'($urandom_range(0, 900));
            set_config($urandom(), fbw, fbh, fbs, scx, scy, scw, sch,
                       $urandom_range(0, 3) == 0);
            idle_gaps = (phase % 3) != 0;
            for (int n = 0; n < 100; n++) begin
                // drain the pipe once in a while with no register change
                if ($urandom_range(0, 149) == 0 || (phase == 4 && n == 50))
                    wait_for_results();
                send_cmd(random_cmd());
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_FILL_COLOR;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_copy_clip();
        test_register_extremes();
        test_random_phases();
        wait_for_results();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
